FILE: design/circle_circle_collision_defines.svh
// ----------------------------------------------------------------------------
// Circle collision assertion macros
// Shared property forms for the collision pipeline checks.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_CIRCLE_COLLISION_DEFINES_SVH
`define CIRCLE_CIRCLE_COLLISION_DEFINES_SVH

// same-cycle implication
`define CCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/ccc_pkg.sv
// ----------------------------------------------------------------------------
// Circle collision package
// Item types, widths and fixed-point helpers shared by the pipeline.
// ----------------------------------------------------------------------------
package ccc_pkg;

  localparam int THR_W      = 16;
  localparam int DIST_W     = 33;
  localparam int RAD_W      = 2 * DIST_W;
  localparam int REM_W      = DIST_W + 4;
  localparam int QUO_W      = 32;
  localparam int SQRT_LAT   = DIST_W;
  localparam logic [THR_W-1:0] THR_RESET = 16'd1;

  typedef struct packed {
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic [31:0]        mass_pair;
    logic [30:0]        radius_a;
    logic [30:0]        radius_b;
    logic [31:0]        restitution_pair;
  } in_item_t;

  typedef struct packed {
    logic               collided;
    logic               degenerate;
    logic signed [31:0] new_pos_a_x;
    logic signed [31:0] new_pos_a_y;
    logic signed [31:0] new_pos_b_x;
    logic signed [31:0] new_pos_b_y;
    logic signed [31:0] new_vel_a_x;
    logic signed [31:0] new_vel_a_y;
    logic signed [31:0] new_vel_b_x;
    logic signed [31:0] new_vel_b_y;
  } out_item_t;

  typedef struct packed {
    in_item_t           item;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [15:0]        ma;
    logic [15:0]        mb;
    logic [15:0]        e;
    logic [16:0]        msum;
    logic [32:0]        kanum;
    logic [32:0]        kbnum;
    logic [DIST_W-1:0]  cdist;
    logic [31:0]        overlap;
    logic               collided;
    logic               degenerate;
  } side_t;

  typedef struct packed {
    logic [QUO_W-1:0] nx;
    logic [QUO_W-1:0] ny;
    logic [QUO_W-1:0] ka;
    logic [QUO_W-1:0] kb;
    logic [QUO_W-1:0] sa;
    logic [QUO_W-1:0] sb;
  } quo_t;

  // arithmetic shift right, rounding toward zero
  function automatic logic signed [79:0] shr_trunc(input logic signed [79:0] x,
                                                   input int unsigned sh);
    logic signed [79:0] bias;
    bias = x[79] ? ((80'sd1 <<< sh) - 80'sd1) : 80'sd0;
    return (x + bias) >>> sh;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
    logic signed [31:0] r;
    if (x > 48'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -48'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

FILE: design/ccc_delay.sv
// ----------------------------------------------------------------------------
// Circle collision side delay
// Shift line that carries item context and valid alongside a datapath unit.
// ----------------------------------------------------------------------------
module ccc_delay #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         adv,
  input  logic         in_valid,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  output logic [W-1:0] out_data
);

  logic [N-1:0] vld_r;
  logic [W-1:0] dat_r [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dat_r[0] <= in_data;
      for (int i = 1; i < N; i++) begin
        dat_r[i] <= dat_r[i-1];
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_data  = dat_r[N-1];

endmodule

FILE: design/ccc_sqrt.sv
// ----------------------------------------------------------------------------
// Circle collision square root
// Pipelined restoring floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module ccc_sqrt (
  input  logic                       clk,
  input  logic                       adv,
  input  logic [ccc_pkg::RAD_W-1:0]  rad,
  output logic [ccc_pkg::DIST_W-1:0] root
);

  import ccc_pkg::*;

  logic [RAD_W-1:0]  rad_r   [DIST_W];
  logic [REM_W-1:0]  rem_r   [DIST_W];
  logic [DIST_W-1:0] root_r  [DIST_W];
  logic [RAD_W-1:0]  rad_nxt [DIST_W];
  logic [REM_W-1:0]  rem_nxt [DIST_W];
  logic [DIST_W-1:0] root_nxt[DIST_W];

  for (genvar k = 0; k < DIST_W; k++) begin : g_stage
    logic [RAD_W-1:0]  prad;
    logic [REM_W-1:0]  prem;
    logic [DIST_W-1:0] proot;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;

    if (k == 0) begin : g_first
      assign prad  = rad;
      assign prem  = '0;
      assign proot = '0;
    end else begin : g_rest
      assign prad  = rad_r[k-1];
      assign prem  = rem_r[k-1];
      assign proot = root_r[k-1];
    end

    always_comb begin
      rem_sh     = {prem[REM_W-3:0], prad[RAD_W-1 -: 2]};
      trial      = {2'b00, proot, 2'b01};
      rad_nxt[k] = prad << 2;
      if (rem_sh >= trial) begin
        rem_nxt[k]  = rem_sh - trial;
        root_nxt[k] = {proot[DIST_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = rem_sh;
        root_nxt[k] = {proot[DIST_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rad_r[k]  <= rad_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
      end
    end
  end

  assign root = root_r[DIST_W-1];

endmodule

FILE: design/ccc_div.sv
// ----------------------------------------------------------------------------
// Circle collision divider
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ccc_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          adv,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem_r   [QW];
  logic [DW-1:0] den_r   [QW];
  logic [QW-1:0] q_r     [QW];
  logic [NW-1:0] rem_nxt [QW];
  logic [QW-1:0] q_nxt   [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int SH = QW - 1 - s;
    logic [NW-1:0] prem;
    logic [DW-1:0] pden;
    logic [QW-1:0] pq;
    logic [CW-1:0] dsh;
    logic [CW-1:0] diff;

    if (s == 0) begin : g_first
      assign prem = num;
      assign pden = den;
      assign pq   = '0;
    end else begin : g_rest
      assign prem = rem_r[s-1];
      assign pden = den_r[s-1];
      assign pq   = q_r[s-1];
    end

    always_comb begin
      dsh  = CW'(pden) << SH;
      diff = CW'(prem) - dsh;
      if (CW'(prem) >= dsh) begin
        rem_nxt[s] = diff[NW-1:0];
        q_nxt[s]   = pq | (QW'(1) << SH);
      end else begin
        rem_nxt[s] = prem;
        q_nxt[s]   = pq;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s] <= rem_nxt[s];
        den_r[s] <= pden;
        q_r[s]   <= q_nxt[s];
      end
    end
  end

  assign quo = q_r[QW-1];

endmodule

FILE: design/ccc_resolve.sv
// ----------------------------------------------------------------------------
// Circle collision resolve
// Normal impulse and positional separation, six register stages.
// ----------------------------------------------------------------------------
module ccc_resolve (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  ccc_pkg::side_t     side,
  input  ccc_pkg::quo_t      quo,
  output logic               out_valid,
  output ccc_pkg::out_item_t out_item
);

  import ccc_pkg::*;

  `include "circle_circle_collision_defines.svh"

  logic r1_v_r, r2_v_r, r3_v_r, r4_v_r, r5_v_r, r6_v_r;
  side_t r1_side_r, r2_side_r, r3_side_r, r4_side_r, r5_side_r, r6_side_r;

  logic signed [31:0] r1_nx_r, r1_ny_r, r2_nx_r, r2_ny_r, r3_nx_r, r3_ny_r;
  logic [16:0] r1_ka_r, r1_kb_r, r2_ka_r, r2_kb_r, r3_ka_r, r3_kb_r;
  logic [16:0] r4_ka_r, r4_kb_r, r5_ka_r, r5_kb_r;
  logic [31:0] r1_sa_r, r1_sb_r, r2_sa_r, r2_sb_r, r3_sa_r, r3_sb_r;
  logic signed [32:0] r1_relx_r, r1_rely_r;
  logic signed [64:0] r2_px_r, r2_py_r;
  logic signed [36:0] r3_vn_r;
  logic signed [68:0] r4_cx_r, r4_cy_r;
  logic signed [64:0] r4_pax_r, r4_pay_r, r4_pbx_r, r4_pby_r;
  logic signed [36:0] r5_cx_r, r5_cy_r;
  logic signed [31:0] r5_pax_r, r5_pay_r, r5_pbx_r, r5_pby_r;
  logic signed [31:0] r6_pax_r, r6_pay_r, r6_pbx_r, r6_pby_r;
  logic signed [54:0] r6_kax_r, r6_kay_r, r6_kbx_r, r6_kby_r;

  logic signed [31:0] nx_nxt, ny_nxt;
  logic signed [79:0] vn_t, cx_t, cy_t, pax_t, pay_t, pbx_t, pby_t;
  logic signed [79:0] kax_t, kay_t, kbx_t, kby_t;
  logic signed [31:0] pax_nxt, pay_nxt, pbx_nxt, pby_nxt;
  logic signed [31:0] vax_new, vay_new, vbx_new, vby_new;
  logic               hit;

  always_comb begin
    nx_nxt = side.dx[32] ? (32'd0 - quo.nx) : quo.nx;
    ny_nxt = side.dy[32] ? (32'd0 - quo.ny) : quo.ny;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_v_r <= 1'b0;
      r2_v_r <= 1'b0;
      r3_v_r <= 1'b0;
      r4_v_r <= 1'b0;
      r5_v_r <= 1'b0;
      r6_v_r <= 1'b0;
    end else if (adv) begin
      r1_v_r <= in_valid;
      r2_v_r <= r1_v_r;
      r3_v_r <= r2_v_r;
      r4_v_r <= r3_v_r;
      r5_v_r <= r4_v_r;
      r6_v_r <= r5_v_r;
    end
  end

  // signed normal, relative velocity
  always_ff @(posedge clk) begin
    if (adv) begin
      r1_side_r <= side;
      r1_nx_r   <= nx_nxt;
      r1_ny_r   <= ny_nxt;
      r1_ka_r   <= quo.ka[16:0];
      r1_kb_r   <= quo.kb[16:0];
      r1_sa_r   <= quo.sa;
      r1_sb_r   <= quo.sb;
      r1_relx_r <= 33'(side.item.vel_a_x) - 33'(side.item.vel_b_x);
      r1_rely_r <= 33'(side.item.vel_a_y) - 33'(side.item.vel_b_y);
    end
  end

  // dot product terms
  always_ff @(posedge clk) begin
    if (adv) begin
      r2_side_r <= r1_side_r;
      r2_nx_r   <= r1_nx_r;
      r2_ny_r   <= r1_ny_r;
      r2_ka_r   <= r1_ka_r;
      r2_kb_r   <= r1_kb_r;
      r2_sa_r   <= r1_sa_r;
      r2_sb_r   <= r1_sb_r;
      r2_px_r   <= r1_relx_r * r1_nx_r;
      r2_py_r   <= r1_rely_r * r1_ny_r;
    end
  end

  assign vn_t = shr_trunc(80'(r2_px_r) + 80'(r2_py_r), 30);

  always_ff @(posedge clk) begin
    if (adv) begin
      r3_side_r <= r2_side_r;
      r3_nx_r   <= r2_nx_r;
      r3_ny_r   <= r2_ny_r;
      r3_ka_r   <= r2_ka_r;
      r3_kb_r   <= r2_kb_r;
      r3_sa_r   <= r2_sa_r;
      r3_sb_r   <= r2_sb_r;
      r3_vn_r   <= vn_t[36:0];
    end
  end

  // normal velocity and separation products
  always_ff @(posedge clk) begin
    if (adv) begin
      r4_side_r <= r3_side_r;
      r4_ka_r   <= r3_ka_r;
      r4_kb_r   <= r3_kb_r;
      r4_cx_r   <= r3_vn_r * r3_nx_r;
      r4_cy_r   <= r3_vn_r * r3_ny_r;
      r4_pax_r  <= $signed({1'b0, r3_sa_r}) * r3_nx_r;
      r4_pay_r  <= $signed({1'b0, r3_sa_r}) * r3_ny_r;
      r4_pbx_r  <= $signed({1'b0, r3_sb_r}) * r3_nx_r;
      r4_pby_r  <= $signed({1'b0, r3_sb_r}) * r3_ny_r;
    end
  end

  always_comb begin
    cx_t    = shr_trunc(80'(r4_cx_r), 30);
    cy_t    = shr_trunc(80'(r4_cy_r), 30);
    pax_t   = shr_trunc(80'(r4_pax_r), 30);
    pay_t   = shr_trunc(80'(r4_pay_r), 30);
    pbx_t   = shr_trunc(80'(r4_pbx_r), 30);
    pby_t   = shr_trunc(80'(r4_pby_r), 30);
    pax_nxt = sat32(48'(r4_side_r.item.pos_a_x) - pax_t[47:0]);
    pay_nxt = sat32(48'(r4_side_r.item.pos_a_y) - pay_t[47:0]);
    pbx_nxt = sat32(48'(r4_side_r.item.pos_b_x) + pbx_t[47:0]);
    pby_nxt = sat32(48'(r4_side_r.item.pos_b_y) + pby_t[47:0]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r5_side_r <= r4_side_r;
      r5_ka_r   <= r4_ka_r;
      r5_kb_r   <= r4_kb_r;
      r5_cx_r   <= cx_t[36:0];
      r5_cy_r   <= cy_t[36:0];
      r5_pax_r  <= pax_nxt;
      r5_pay_r  <= pay_nxt;
      r5_pbx_r  <= pbx_nxt;
      r5_pby_r  <= pby_nxt;
    end
  end

  // impulse products
  always_ff @(posedge clk) begin
    if (adv) begin
      r6_side_r <= r5_side_r;
      r6_pax_r  <= r5_pax_r;
      r6_pay_r  <= r5_pay_r;
      r6_pbx_r  <= r5_pbx_r;
      r6_pby_r  <= r5_pby_r;
      r6_kax_r  <= r5_cx_r * $signed({1'b0, r5_ka_r});
      r6_kay_r  <= r5_cy_r * $signed({1'b0, r5_ka_r});
      r6_kbx_r  <= r5_cx_r * $signed({1'b0, r5_kb_r});
      r6_kby_r  <= r5_cy_r * $signed({1'b0, r5_kb_r});
    end
  end

  always_comb begin
    kax_t   = shr_trunc(80'(r6_kax_r), 16);
    kay_t   = shr_trunc(80'(r6_kay_r), 16);
    kbx_t   = shr_trunc(80'(r6_kbx_r), 16);
    kby_t   = shr_trunc(80'(r6_kby_r), 16);
    vax_new = sat32(48'(r6_side_r.item.vel_a_x) - kax_t[47:0]);
    vay_new = sat32(48'(r6_side_r.item.vel_a_y) - kay_t[47:0]);
    vbx_new = sat32(48'(r6_side_r.item.vel_b_x) + kbx_t[47:0]);
    vby_new = sat32(48'(r6_side_r.item.vel_b_y) + kby_t[47:0]);
    hit     = r6_side_r.collided && !r6_side_r.degenerate;

    out_item.collided    = r6_side_r.collided;
    out_item.degenerate  = r6_side_r.degenerate;
    out_item.new_pos_a_x = hit ? r6_pax_r : r6_side_r.item.pos_a_x;
    out_item.new_pos_a_y = hit ? r6_pay_r : r6_side_r.item.pos_a_y;
    out_item.new_pos_b_x = hit ? r6_pbx_r : r6_side_r.item.pos_b_x;
    out_item.new_pos_b_y = hit ? r6_pby_r : r6_side_r.item.pos_b_y;
    out_item.new_vel_a_x = hit ? vax_new : r6_side_r.item.vel_a_x;
    out_item.new_vel_a_y = hit ? vay_new : r6_side_r.item.vel_a_y;
    out_item.new_vel_b_x = hit ? vbx_new : r6_side_r.item.vel_b_x;
    out_item.new_vel_b_y = hit ? vby_new : r6_side_r.item.vel_b_y;
  end

  assign out_valid = r6_v_r;

  `CCC_ASSERT_IMP(a_nx_unit, r1_v_r && r1_side_r.collided && !r1_side_r.degenerate, (r1_nx_r <= 32'sd1073741824) && (r1_nx_r >= -32'sd1073741824), "normal x out of unit range")
  `CCC_ASSERT_IMP(a_sa_le_overlap, r1_v_r && r1_side_r.collided && !r1_side_r.degenerate, r1_sa_r <= r1_side_r.overlap, "separation exceeds overlap")
  `CCC_ASSERT_IMP(a_k_sum, r1_v_r && r1_side_r.collided && !r1_side_r.degenerate, (18'(r1_ka_r) + 18'(r1_kb_r)) <= (18'(r1_side_r.e) + 18'd65536), "impulse weights exceed total")

endmodule

FILE: design/circle_circle_collision.sv
// ----------------------------------------------------------------------------
// Circle circle collision
// Contact resolution for a pair of 2D circles per item, Q16.16 datapath.
//
//   channel  | ports                          | item
//   ---------+--------------------------------+--------------------------
//   input    | in_valid, in_stall, in_item    | two bodies
//   result   | out_valid, out_stall, out_item | flags, updated bodies
//   config   | cfg_we, cfg_wdata              | overlap threshold
//
// One item per cycle while the output is not stalled; the path runs the front stages,
// the 33 stage square root, the post-root stages, the 32 stage dividers, resolve, output.
// Reset clears all valid bits and sets the threshold to 1.
// The whole pipeline holds while the output register is full and stalled.
// ----------------------------------------------------------------------------
module circle_circle_collision (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ccc_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ccc_pkg::out_item_t             out_item,
  input  logic                           cfg_we,
  input  logic [ccc_pkg::THR_W-1:0]      cfg_wdata
);

  import ccc_pkg::*;

  `include "circle_circle_collision_defines.svh"

  logic              adv;
  logic [THR_W-1:0]  thr_r;
  logic              s1_v_r, s2_v_r, s3_v_r, p1_v_r, p2_v_r;
  side_t             s1_side_r, s2_side_r, s3_side_r, p1_side_r, p2_side_r;
  side_t             s1_nxt, s2_nxt, p1_nxt;
  logic [64:0]       sqx_r, sqy_r;
  logic [RAD_W-1:0]  rad_r;
  logic [31:0]       eprod;
  logic [32:0]       ux, uy;
  logic [32:0]       p1ux, p1uy;
  logic [33:0]       ov;
  logic [62:0]       nnx_r, nny_r;
  logic [DIST_W-1:0] dden_r;
  logic [32:0]       kanum_r, kbnum_r;
  logic [16:0]       msum_r;
  logic [47:0]       sanum_r, sbnum_r;
  logic [DIST_W-1:0] root;
  logic              sq_v;
  logic [$bits(side_t)-1:0] sq_side_bits, dv_side_bits;
  side_t             sq_side, dv_side;
  logic              dv_v;
  quo_t              quo;
  logic              res_v;
  out_item_t         res_item;
  logic              out_valid_r;
  out_item_t         out_item_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // centre difference, restitution product, mass fix-up
  always_comb begin
    eprod           = 32'(in_item.restitution_pair[15:0]) *
                      32'(in_item.restitution_pair[31:16]);
    s1_nxt          = '0;
    s1_nxt.item     = in_item;
    s1_nxt.dx       = 33'(in_item.pos_b_x) - 33'(in_item.pos_a_x);
    s1_nxt.dy       = 33'(in_item.pos_b_y) - 33'(in_item.pos_a_y);
    s1_nxt.e        = eprod[31:16];
    s1_nxt.ma       = in_item.mass_pair[15:0];
    s1_nxt.mb       = in_item.mass_pair[31:16];
    if (in_item.mass_pair == 32'd0) begin
      s1_nxt.ma = 16'd1;
      s1_nxt.mb = 16'd1;
    end
  end

  // squares and mass weights
  always_comb begin
    ux           = s1_side_r.dx[32] ? (33'd0 - s1_side_r.dx) : s1_side_r.dx;
    uy           = s1_side_r.dy[32] ? (33'd0 - s1_side_r.dy) : s1_side_r.dy;
    s2_nxt       = s1_side_r;
    s2_nxt.msum  = 17'(s1_side_r.ma) + 17'(s1_side_r.mb);
    s2_nxt.kanum = 33'(s1_side_r.mb) * 33'(17'h10000 + 17'(s1_side_r.e));
    s2_nxt.kbnum = 33'(s1_side_r.ma) * 33'(17'h10000 + 17'(s1_side_r.e));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      p1_v_r <= sq_v;
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side_r <= s1_nxt;
      s2_side_r <= s2_nxt;
      sqx_r     <= 65'(ux) * 65'(ux);
      sqy_r     <= 65'(uy) * 65'(uy);
      s3_side_r <= s2_side_r;
      rad_r     <= RAD_W'(sqx_r) + RAD_W'(sqy_r);
    end
  end

  ccc_sqrt u_sqrt (
    .clk  (clk),
    .adv  (adv),
    .rad  (rad_r),
    .root (root)
  );

  ccc_delay #(
    .W ($bits(side_t)),
    .N (SQRT_LAT)
  ) u_sq_delay (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s3_v_r),
    .in_data   (s3_side_r),
    .out_valid (sq_v),
    .out_data  (sq_side_bits)
  );

  assign sq_side = sq_side_bits;

  // overlap and collision test
  always_comb begin
    ov                = 34'(sq_side.item.radius_a) + 34'(sq_side.item.radius_b) -
                        34'(root);
    p1_nxt            = sq_side;
    p1_nxt.cdist      = root;
    p1_nxt.overlap    = ov[31:0];
    p1_nxt.collided   = $signed(ov) > $signed({18'd0, thr_r});
    p1_nxt.degenerate = p1_nxt.collided && (root == '0);
  end

  always_comb begin
    p1ux = p1_side_r.dx[32] ? (33'd0 - p1_side_r.dx) : p1_side_r.dx;
    p1uy = p1_side_r.dy[32] ? (33'd0 - p1_side_r.dy) : p1_side_r.dy;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_side_r <= p1_nxt;
      p2_side_r <= p1_side_r;
      nnx_r     <= {p1ux[32:0], 30'd0};
      nny_r     <= {p1uy[32:0], 30'd0};
      dden_r    <= p1_side_r.cdist;
      kanum_r   <= p1_side_r.kanum;
      kbnum_r   <= p1_side_r.kbnum;
      msum_r    <= p1_side_r.msum;
      sanum_r   <= 48'(p1_side_r.overlap) * 48'(p1_side_r.mb);
      sbnum_r   <= 48'(p1_side_r.overlap) * 48'(p1_side_r.ma);
    end
  end

  ccc_div #(.NW(63), .DW(DIST_W), .QW(QUO_W)) u_div_nx (
    .clk (clk), .adv (adv), .num (nnx_r), .den (dden_r), .quo (quo.nx)
  );

  ccc_div #(.NW(63), .DW(DIST_W), .QW(QUO_W)) u_div_ny (
    .clk (clk), .adv (adv), .num (nny_r), .den (dden_r), .quo (quo.ny)
  );

  ccc_div #(.NW(33), .DW(17), .QW(QUO_W)) u_div_ka (
    .clk (clk), .adv (adv), .num (kanum_r), .den (msum_r), .quo (quo.ka)
  );

  ccc_div #(.NW(33), .DW(17), .QW(QUO_W)) u_div_kb (
    .clk (clk), .adv (adv), .num (kbnum_r), .den (msum_r), .quo (quo.kb)
  );

  ccc_div #(.NW(48), .DW(17), .QW(QUO_W)) u_div_sa (
    .clk (clk), .adv (adv), .num (sanum_r), .den (msum_r), .quo (quo.sa)
  );

  ccc_div #(.NW(48), .DW(17), .QW(QUO_W)) u_div_sb (
    .clk (clk), .adv (adv), .num (sbnum_r), .den (msum_r), .quo (quo.sb)
  );

  ccc_delay #(
    .W ($bits(side_t)),
    .N (QUO_W)
  ) u_dv_delay (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (p2_v_r),
    .in_data   (p2_side_r),
    .out_valid (dv_v),
    .out_data  (dv_side_bits)
  );

  assign dv_side = dv_side_bits;

  ccc_resolve u_resolve (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (dv_v),
    .side      (dv_side),
    .quo       (quo),
    .out_valid (res_v),
    .out_item  (res_item)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `CCC_ASSERT_NXT(a_accept_enters, in_valid && !in_stall, s1_v_r, "accepted item missing from first stage")
  `CCC_ASSERT_IMP(a_hit_overlap, p1_v_r && p1_side_r.collided, p1_side_r.overlap != 32'd0, "collision with zero overlap")
  `CCC_ASSERT_IMP(a_degen_collided, out_valid_r && out_item_r.degenerate, out_item_r.collided, "degenerate without collision")

endmodule
